// ===== design/smds_pkg.sv =====
`default_nettype none
package smds_pkg;

    localparam int DEPTH = 128;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_PEEK = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic [1:0]         operation;
        logic               stack_select;
        logic signed [31:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [1:0]         status;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } t_state;

    typedef struct packed {
        logic capture;
        logic exec;
    } t_dp_cmd;

endpackage
`default_nettype wire

// ===== design/smds_ctrl.sv =====
`default_nettype none
module smds_ctrl
    import smds_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall    = 1'b1;
        o_out_valid   = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.exec    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            S_RESP: begin
                o_out_valid = 1'b1;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== design/smds_dpath.sv =====
`default_nettype none
module smds_dpath
    import smds_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_dp_cmd  i_cmd,
    input  wire t_in_item i_in_item,
    output t_out_item     o_out_item
);

    logic [31:0]   r_mem [DEPTH];

    logic [1:0]    r_op;
    logic          r_sel;
    logic [31:0]   r_val;
    logic [CW-1:0] r_low;
    logic [CW-1:0] r_high;
    logic [CW-1:0] n_low;
    logic [CW-1:0] n_high;
    logic [1:0]    r_status;
    logic [1:0]    n_status;
    logic          r_rd_ok;
    logic          n_rd_ok;
    logic [31:0]   r_rd_data;

    logic [CW:0]   w_sum;
    logic          w_full;
    logic          w_empty;
    logic          w_we;
    logic [CW-1:0] w_addr_full;
    logic [AW-1:0] w_addr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_in_item.operation;
            r_sel <= i_in_item.stack_select;
            r_val <= i_in_item.push_value;
        end
    end

    always_comb begin
        w_sum       = {1'b0, r_low} + {1'b0, r_high};
        w_full      = (w_sum == (CW + 1)'(DEPTH));
        w_empty     = r_sel ? (r_high == '0) : (r_low == '0);
        n_low       = r_low;
        n_high      = r_high;
        n_status    = ST_OK;
        n_rd_ok     = 1'b0;
        w_we        = 1'b0;
        w_addr_full = '0;
        case (r_op)
            OP_PUSH: begin
                w_addr_full = r_sel ? (CW'(DEPTH - 1) - r_high) : r_low;
                if (w_full) begin
                    n_status = ST_OVERFLOW;
                end else begin
                    w_we = 1'b1;
                    if (r_sel) begin
                        n_high = r_high + CW'(1);
                    end else begin
                        n_low = r_low + CW'(1);
                    end
                end
            end
            OP_POP, OP_PEEK: begin
                w_addr_full = r_sel ? (CW'(DEPTH) - r_high) : (r_low - CW'(1));
                if (w_empty) begin
                    n_status = ST_UNDERFLOW;
                end else begin
                    n_rd_ok = 1'b1;
                    if (r_op == OP_POP) begin
                        if (r_sel) begin
                            n_high = r_high - CW'(1);
                        end else begin
                            n_low = r_low - CW'(1);
                        end
                    end
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
        w_addr = w_addr_full[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= '0;
            r_high <= '0;
        end else if (i_cmd.exec) begin
            r_low  <= n_low;
            r_high <= n_high;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_rd_ok  <= n_rd_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_we) begin
            r_mem[w_addr] <= r_val;
        end
        if (i_cmd.exec) begin
            r_rd_data <= r_mem[w_addr];
        end
    end

    assign o_out_item.read_value = r_rd_ok ? r_rd_data : '0;
    assign o_out_item.status     = r_status;

endmodule
`default_nettype wire

// ===== design/shared_memory_dual_stack_core.sv =====
// Channel  | Valid        | Stall        | Payload
// ---------+--------------+--------------+---------------------------
// input    | i_in_valid   | o_in_stall   | i_in_item  (t_in_item)
// output   | o_out_valid  | i_out_stall  | o_out_item (t_out_item)
//
// One item at a time: capture, one memory access, result, in the
// three-state controller. A new item waits until the result is taken.
// Synchronous active-low reset empties both stacks; store contents are
// not cleared. While a result is stalled, o_in_stall stays high.
`default_nettype none
module shared_memory_dual_stack_core
    import smds_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_item i_in_item,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_out_item     o_out_item
);

    t_dp_cmd w_cmd;

    smds_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    smds_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_in_item  (i_in_item),
        .o_out_item (o_out_item)
    );

endmodule
`default_nettype wire

// ===== design/smds_checker.sv =====
`default_nettype none
module smds_checker
    import smds_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_stall,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item o_out_item
);

    a_busy_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while a result is pending");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (o_in_stall && !o_out_valid))
        else $error("second item accepted or early result");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall) |=> !o_out_valid)
        else $error("result repeated");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.status != ST_OK)) |->
        ((o_out_item.read_value == 32'sd0) &&
         ((o_out_item.status == ST_OVERFLOW) || (o_out_item.status == ST_UNDERFLOW))))
        else $error("bad status or nonzero value on error");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed");

endmodule

bind shared_memory_dual_stack_core smds_checker u_smds_checker (.*);
`default_nettype wire
